### src/mtwg_pkg.sv
// Shared constants and the output tempering function of the MT19937 word generator.
package mtwg_pkg;

    localparam int unsigned STATE_WORDS_DEF  = 624;
    localparam int unsigned TWIST_OFFSET_DEF = 397;

    localparam logic [31:0] TWIST_XOR    = 32'h9908_b0df;
    localparam logic [31:0] HIGH_BIT     = 32'h8000_0000;
    localparam logic [31:0] LOW_BITS     = 32'h7fff_ffff;
    localparam logic [31:0] TEMPER_B     = 32'h9d2c_5680;
    localparam logic [31:0] TEMPER_C     = 32'hefc6_0000;
    localparam logic [31:0] SEED_MULT    = 32'd6069;
    localparam logic [31:0] DEFAULT_SEED = 32'd4357;

    // Scramble one state word into an output word.
    function automatic logic [31:0] temper(input logic [31:0] w);
        logic [31:0] y;
        y = w ^ (w >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

### src/mt19937_word_generator.sv
// Top level of the MT19937 word generator: sequencer, state memory and output register.
//
//  channel   direction  handshake               payload
//  -------   ---------  ----------------------  -----------------------------
//  in        sink       in_valid / in_ready     reseed (1 bit)
//  out       source     out_valid / out_ready   random_word (32 bits)
//  cfg       sink       cfg_write_en            cfg_write_data -> seed word
//
//  A plain draw goes from transaction to result through accept, memory
//  read and temper into the output register.
//  A draw that needs a twist runs it first: each state word gets a read
//  (both RAM ports) and then a write.
//  A reseed, or the first draw after reset, fills all STATE_WORDS words
//  (one multiply-by-6069 per cycle) ahead of that twist.
//  Reset initialises the registers only; the state memory is never cleared,
//  since it is always filled before it is read.
//  A stalled output holds the result in its register; the next transaction
//  is still taken and waits after its memory read until the register frees.
module mt19937_word_generator #(
    parameter int unsigned STATE_WORDS  = mtwg_pkg::STATE_WORDS_DEF,
    parameter int unsigned TWIST_OFFSET = mtwg_pkg::TWIST_OFFSET_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [31:0] cfg_write_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        reseed,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] random_word
);

    import mtwg_pkg::*;

    localparam int unsigned ADDR_W = $clog2(STATE_WORDS);
    // Position must hold STATE_WORDS + 1, the never-seeded mark.
    localparam int unsigned POS_W  = $clog2(STATE_WORDS + 2);

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STATE_WORDS - 1);
    localparam logic [ADDR_W-1:0] FAR_INIT  = ADDR_W'(TWIST_OFFSET % STATE_WORDS);
    localparam logic [POS_W-1:0]  POS_DUE   = POS_W'(STATE_WORDS);
    localparam logic [POS_W-1:0]  POS_NEVER = POS_W'(STATE_WORDS + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_TW_PRIME,
        ST_TW_LOAD,
        ST_TW_READ,
        ST_TW_WRITE,
        ST_RD,
        ST_RD_WAIT
    } state_t;

    state_t             state_reg,     state_next;
    logic [POS_W-1:0]   pos_reg,       pos_next;
    logic [ADDR_W-1:0]  idx_reg,       idx_next;
    logic [ADDR_W-1:0]  far_reg,       far_next;
    logic [31:0]        cur_reg,       cur_next;
    logic [31:0]        fill_reg,      fill_next;
    logic [31:0]        seed_reg,      seed_next;
    logic [31:0]        word_reg,      word_next;
    logic               out_valid_reg, out_valid_next;

    // State memory ports
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [31:0]        ram_wdata;
    logic               ram_re_a;
    logic [ADDR_W-1:0]  ram_raddr_a;
    logic [31:0]        ram_rdata_a;
    logic               ram_re_b;
    logic [31:0]        ram_rdata_b;

    logic [ADDR_W-1:0]  nxt_addr;
    logic [31:0]        mix_word;
    logic [31:0]        twist_word;
    logic               out_free;

    mtwg_ram #(
        .WIDTH (32),
        .DEPTH (STATE_WORDS)
    ) u_state_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .re_a    (ram_re_a),
        .raddr_a (ram_raddr_a),
        .rdata_a (ram_rdata_a),
        .re_b    (ram_re_b),
        .raddr_b (far_reg),
        .rdata_b (ram_rdata_b)
    );

    // Neighbor index wraps to the start on the last word.
    assign nxt_addr = (idx_reg == LAST_ADDR) ? '0 : idx_reg + 1'b1;

    // One twist step: cur_reg holds the old word at idx, port A the
    // neighbor, port B the partner word.
    assign mix_word   = (cur_reg & HIGH_BIT) | (ram_rdata_a & LOW_BITS);
    assign twist_word = ram_rdata_b ^ (mix_word >> 1) ^ (mix_word[0] ? TWIST_XOR : 32'd0);

    assign out_free = !out_valid_reg || out_ready;

    assign ram_we    = (state_reg == ST_FILL) || (state_reg == ST_TW_WRITE);
    assign ram_waddr = idx_reg;
    assign ram_wdata = (state_reg == ST_FILL) ? fill_reg : twist_word;
    assign ram_re_a  = (state_reg == ST_TW_PRIME) || (state_reg == ST_TW_READ)
                    || (state_reg == ST_RD);
    assign ram_re_b  = (state_reg == ST_TW_READ);

    always_comb
    begin
        unique case (state_reg)
            ST_TW_PRIME: ram_raddr_a = '0;
            ST_TW_READ:  ram_raddr_a = nxt_addr;
            default:     ram_raddr_a = pos_reg[ADDR_W-1:0];
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        idx_next       = idx_reg;
        far_next       = far_reg;
        cur_next       = cur_reg;
        fill_next      = fill_reg;
        word_next      = word_reg;
        seed_next      = cfg_write_en ? cfg_write_data : seed_reg;
        // Drop the result once the consumer takes it.
        out_valid_next = out_valid_reg && !out_ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    idx_next = '0;
                    if (reseed)
                    begin
                        fill_next  = seed_reg;
                        state_next = ST_FILL;
                    end
                    else if (pos_reg == POS_NEVER)
                    begin
                        fill_next  = DEFAULT_SEED;
                        state_next = ST_FILL;
                    end
                    else if (pos_reg == POS_DUE)
                    begin
                        state_next = ST_TW_PRIME;
                    end
                    else
                    begin
                        state_next = ST_RD;
                    end
                end
            end
            ST_FILL:
            begin
                fill_next = fill_reg * SEED_MULT;
                if (idx_reg == LAST_ADDR)
                begin
                    pos_next   = POS_DUE;
                    state_next = ST_TW_PRIME;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_TW_PRIME:
            begin
                idx_next   = '0;
                far_next   = FAR_INIT;
                state_next = ST_TW_LOAD;
            end
            ST_TW_LOAD:
            begin
                cur_next   = ram_rdata_a;
                state_next = ST_TW_READ;
            end
            ST_TW_READ:
            begin
                state_next = ST_TW_WRITE;
            end
            ST_TW_WRITE:
            begin
                // Old neighbor becomes the current word of the next step.
                cur_next = ram_rdata_a;
                far_next = (far_reg == LAST_ADDR) ? '0 : far_reg + 1'b1;
                if (idx_reg == LAST_ADDR)
                begin
                    pos_next   = '0;
                    state_next = ST_RD;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_TW_READ;
                end
            end
            ST_RD:
            begin
                pos_next   = pos_reg + 1'b1;
                state_next = ST_RD_WAIT;
            end
            ST_RD_WAIT:
            begin
                if (out_free)
                begin
                    word_next      = temper(ram_rdata_a);
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= POS_NEVER;
            idx_reg       <= '0;
            far_reg       <= '0;
            cur_reg       <= '0;
            fill_reg      <= '0;
            seed_reg      <= DEFAULT_SEED;
            word_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            idx_reg       <= idx_next;
            far_reg       <= far_next;
            cur_reg       <= cur_next;
            fill_reg      <= fill_next;
            seed_reg      <= seed_next;
            word_reg      <= word_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign random_word = word_reg;

    // A write and a read never share a cycle, so a twist step always sees
    // the words written by earlier steps.
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> !(ram_re_a || ram_re_b))
        else $error("state memory read and write in the same cycle");

    // A draw only reads inside the store.
    a_draw_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD) |-> (pos_reg < POS_DUE))
        else $error("draw position beyond the state store");

    // A finished twist always restarts the read position.
    a_twist_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TW_WRITE && idx_reg == LAST_ADDR) |=>
            (pos_reg == '0 && state_reg == ST_RD))
        else $error("twist end did not restart the read position");

    // A result is loaded only when the output register is free.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD_WAIT && out_valid_reg && !out_ready) |=>
            (state_reg == ST_RD_WAIT))
        else $error("result loaded over a waiting result");

endmodule

### src/mtwg_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
module mtwg_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 624
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [$clog2(DEPTH)-1:0]   waddr,
    input  logic [WIDTH-1:0]           wdata,
    input  logic                       re_a,
    input  logic [$clog2(DEPTH)-1:0]   raddr_a,
    output logic [WIDTH-1:0]           rdata_a,
    input  logic                       re_b,
    input  logic [$clog2(DEPTH)-1:0]   raddr_b,
    output logic [WIDTH-1:0]           rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re_a)
        begin
            rdata_a_reg <= mem_reg[raddr_a];
        end
        if (re_b)
        begin
            rdata_b_reg <= mem_reg[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule
